### src/brp_pkg.sv
// Shared types and constants for the binding record parser.
`default_nettype none

package brp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned MaxKeys   = 8;
  localparam int unsigned OffsetW   = 32;
  localparam int unsigned KeyTotalW = 4;
  localparam int unsigned ButtonW   = 5;
  localparam int unsigned CfgIdxW   = 3;

  // Buttons at or above this id are not bindable.
  localparam logic [ButtonW-1:0] WheelId = 5'd20;
  // Buttons 16..19 are analog axes: button[4:2] equals this group.
  localparam logic [2:0] AnalogGroup = 3'd4;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_FLOOR   = 3'd0,
    CFG_KEY_CEILING = 3'd1,
    CFG_MOUSE_FIRST = 3'd2,
    CFG_MOUSE_LAST  = 3'd3,
    CFG_JOY_FIRST   = 3'd4,
    CFG_JOY_LAST    = 3'd5,
    CFG_JOY2_FIRST  = 3'd6,
    CFG_JOY2_LAST   = 3'd7
  } cfg_idx_e;

  localparam logic [ByteW-1:0] KeyFloorRst   = 8'd0;
  localparam logic [ByteW-1:0] KeyCeilingRst = 8'd106;
  localparam logic [ByteW-1:0] MouseFirstRst = 8'd200;
  localparam logic [ByteW-1:0] MouseLastRst  = 8'd206;
  localparam logic [ByteW-1:0] JoyFirstRst   = 8'd210;
  localparam logic [ByteW-1:0] JoyLastRst    = 8'd217;
  localparam logic [ByteW-1:0] Joy2FirstRst  = 8'd218;
  localparam logic [ByteW-1:0] Joy2LastRst   = 8'd221;

  typedef struct packed {
    logic [ByteW-1:0] key_floor;
    logic [ByteW-1:0] key_ceiling;
    logic [ByteW-1:0] mouse_first;
    logic [ByteW-1:0] mouse_last;
    logic [ByteW-1:0] joy_first;
    logic [ByteW-1:0] joy_last;
    logic [ByteW-1:0] joy2_first;
    logic [ByteW-1:0] joy2_last;
  } cfg_t;

  typedef struct packed {
    logic playable;
    logic joystick;
  } key_class_t;

endpackage

`default_nettype wire

### src/binding_record_parser.sv
// Binding record parser: turns a byte stream of gamepad binding records into bindings.
//
// Input channel: one stream byte per beat. A beat with start_req_i set carries the
// record count of a new list and abandons any list in progress. Each record is a
// header byte, an optional base-128 name offset and one to eight key bytes.
// Output channel: one beat per kept record, taken from a result register. The last
// beat of a list carries last_o and uses_joystick_o; a list whose final record is
// dropped, or whose count is zero, ends with a beat that has bind_valid_o low.
// Throughput: one input byte per cycle until a result waits on a stalled receiver;
// then every byte waits, whether or not it completes a record. A result appears in
// the cycle after the byte that completes it is accepted. in_ready_o stays high while
// the result register is empty or its beat is being taken in the same cycle, so a
// stalled receiver holds off the input only once a result waits.
// Reset: all ranges take their default values, no list is open and the result
// register is empty. Configuration writes take effect at the next edge.
`default_nettype none

module binding_record_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [brp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [brp_pkg::ByteW-1:0]           cfg_data_i,
  // input stream
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [brp_pkg::ByteW-1:0]           data_byte_i,
  input  logic                                start_req_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                bind_valid_o,
  output logic [brp_pkg::ButtonW-1:0]         button_o,
  output logic                                analog_o,
  output logic [brp_pkg::KeyTotalW-1:0]       key_total_o,
  output logic                                has_name_o,
  output logic [brp_pkg::OffsetW-1:0]         name_offset_o,
  output logic [brp_pkg::MaxKeys*brp_pkg::ByteW-1:0] keys_o,
  output logic                                last_o,
  output logic                                uses_joystick_o
);

  localparam int unsigned KeysW = brp_pkg::MaxKeys * brp_pkg::ByteW;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_OFFSET, PH_KEYS} phase_e;

  typedef struct packed {
    logic                            bind_valid;
    logic [brp_pkg::ButtonW-1:0]     button;
    logic                            analog;
    logic [brp_pkg::KeyTotalW-1:0]   key_total;
    logic                            has_name;
    logic [brp_pkg::OffsetW-1:0]     name_offset;
    logic [KeysW-1:0]                keys;
    logic                            last;
    logic                            uses_joystick;
  } result_t;

  // configuration
  brp_pkg::cfg_t cfg_q;

  // parser state
  phase_e                          phase_q, phase_d;
  logic [7:0]                      records_left_q, records_left_d;
  logic [brp_pkg::ButtonW-1:0]     cur_button_q, cur_button_d;
  logic                            cur_has_name_q, cur_has_name_d;
  logic [brp_pkg::KeyTotalW-1:0]   cur_key_total_q, cur_key_total_d;
  logic [brp_pkg::KeyTotalW-1:0]   key_index_q, key_index_d;
  logic [brp_pkg::OffsetW-1:0]     offset_accum_q, offset_accum_d;
  logic [KeysW-1:0]                key_buffer_q, key_buffer_d;
  logic                            keys_playable_q, keys_playable_d;
  logic                            joystick_seen_q, joystick_seen_d;

  // result register
  logic    res_valid_q, res_valid_d;
  result_t res_q, res_d;

  logic in_fire;
  brp_pkg::key_class_t byte_class;
  brp_pkg::key_class_t lane_class [brp_pkg::MaxKeys];
  logic [KeysW-1:0] key_insert;
  logic [KeysW-1:0] key_merged;
  logic [brp_pkg::MaxKeys-1:0] lane_joy;
  logic [brp_pkg::KeyTotalW-1:0] key_index_inc;
  logic [7:0] records_dec;
  logic [brp_pkg::ButtonW-1:0] hdr_button;
  logic hdr_analog;
  logic rec_analog;
  logic rec_playable;

  assign in_ready_o = !res_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  brp_key_class u_byte_class (
    .key_i   (data_byte_i),
    .cfg_i   (cfg_q),
    .class_o (byte_class)
  );

  // Place the byte at its slot; the slot is still zero from the header.
  assign key_insert = {{(KeysW-brp_pkg::ByteW){1'b0}}, data_byte_i}
                      << {key_index_q[2:0], 3'b000};
  assign key_merged = key_buffer_q | key_insert;

  // Joystick check over the completed record, with the ranges in force now.
  for (genvar g = 0; g < brp_pkg::MaxKeys; g++) begin : g_lane
    brp_key_class u_lane_class (
      .key_i   (key_merged[g*brp_pkg::ByteW +: brp_pkg::ByteW]),
      .cfg_i   (cfg_q),
      .class_o (lane_class[g])
    );
    assign lane_joy[g] = lane_class[g].joystick
                         && (brp_pkg::KeyTotalW'(g) < cur_key_total_q);
  end

  assign key_index_inc = key_index_q + 1'b1;
  assign records_dec   = records_left_q - 1'b1;
  assign hdr_button    = data_byte_i[4:0];
  assign hdr_analog    = hdr_button[4:2] == brp_pkg::AnalogGroup;
  assign rec_analog    = cur_button_q[4:2] == brp_pkg::AnalogGroup;
  assign rec_playable  = keys_playable_q && byte_class.playable;

  always_comb begin
    phase_d         = phase_q;
    records_left_d  = records_left_q;
    cur_button_d    = cur_button_q;
    cur_has_name_d  = cur_has_name_q;
    cur_key_total_d = cur_key_total_q;
    key_index_d     = key_index_q;
    offset_accum_d  = offset_accum_q;
    key_buffer_d    = key_buffer_q;
    keys_playable_d = keys_playable_q;
    joystick_seen_d = joystick_seen_q;
    res_valid_d     = res_valid_q && !out_ready_i;
    res_d           = res_q;

    if (in_fire) begin
      if (start_req_i) begin
        records_left_d  = data_byte_i;
        joystick_seen_d = 1'b0;
        if (data_byte_i == '0) begin
          phase_d     = PH_IDLE;
          res_valid_d = 1'b1;
          res_d       = '0;
          res_d.last  = 1'b1;
        end else begin
          phase_d = PH_HEADER;
        end
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            cur_button_d    = hdr_button;
            cur_has_name_d  = data_byte_i[5];
            cur_key_total_d = {1'b0, {1'b0, data_byte_i[7:6]} + 3'd1}
                              << hdr_analog;
            key_index_d     = '0;
            offset_accum_d  = '0;
            key_buffer_d    = '0;
            keys_playable_d = hdr_button < brp_pkg::WheelId;
            phase_d         = data_byte_i[5] ? PH_OFFSET : PH_KEYS;
          end
          PH_OFFSET: begin
            offset_accum_d = {offset_accum_q[brp_pkg::OffsetW-8:0], data_byte_i[6:0]};
            if (!data_byte_i[7]) phase_d = PH_KEYS;
          end
          PH_KEYS: begin
            key_buffer_d    = key_merged;
            keys_playable_d = rec_playable;
            key_index_d     = key_index_inc;
            if (key_index_inc >= cur_key_total_q) begin
              records_left_d = records_dec;
              phase_d        = (records_dec != '0) ? PH_HEADER : PH_IDLE;
              if (rec_playable) begin
                joystick_seen_d     = joystick_seen_q || (lane_joy != '0);
                res_valid_d         = 1'b1;
                res_d.bind_valid    = 1'b1;
                res_d.button        = cur_button_q;
                res_d.analog        = rec_analog;
                res_d.key_total     = cur_key_total_q;
                res_d.has_name      = cur_has_name_q;
                res_d.name_offset   = cur_has_name_q ? offset_accum_q : '0;
                res_d.keys          = key_merged;
                res_d.last          = records_dec == '0;
                res_d.uses_joystick = (records_dec == '0) && joystick_seen_d;
              end else if (records_dec == '0) begin
                // Dropped final record: close the list with a bare marker.
                res_valid_d         = 1'b1;
                res_d               = '0;
                res_d.last          = 1'b1;
                res_d.uses_joystick = joystick_seen_q;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      records_left_q  <= '0;
      cur_button_q    <= '0;
      cur_has_name_q  <= 1'b0;
      cur_key_total_q <= '0;
      key_index_q     <= '0;
      offset_accum_q  <= '0;
      key_buffer_q    <= '0;
      keys_playable_q <= 1'b1;
      joystick_seen_q <= 1'b0;
      res_valid_q     <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      records_left_q  <= records_left_d;
      cur_button_q    <= cur_button_d;
      cur_has_name_q  <= cur_has_name_d;
      cur_key_total_q <= cur_key_total_d;
      key_index_q     <= key_index_d;
      offset_accum_q  <= offset_accum_d;
      key_buffer_q    <= key_buffer_d;
      keys_playable_q <= keys_playable_d;
      joystick_seen_q <= joystick_seen_d;
      res_valid_q     <= res_valid_d;
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_floor   <= brp_pkg::KeyFloorRst;
      cfg_q.key_ceiling <= brp_pkg::KeyCeilingRst;
      cfg_q.mouse_first <= brp_pkg::MouseFirstRst;
      cfg_q.mouse_last  <= brp_pkg::MouseLastRst;
      cfg_q.joy_first   <= brp_pkg::JoyFirstRst;
      cfg_q.joy_last    <= brp_pkg::JoyLastRst;
      cfg_q.joy2_first  <= brp_pkg::Joy2FirstRst;
      cfg_q.joy2_last   <= brp_pkg::Joy2LastRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        brp_pkg::CFG_KEY_FLOOR:   cfg_q.key_floor   <= cfg_data_i;
        brp_pkg::CFG_KEY_CEILING: cfg_q.key_ceiling <= cfg_data_i;
        brp_pkg::CFG_MOUSE_FIRST: cfg_q.mouse_first <= cfg_data_i;
        brp_pkg::CFG_MOUSE_LAST:  cfg_q.mouse_last  <= cfg_data_i;
        brp_pkg::CFG_JOY_FIRST:   cfg_q.joy_first   <= cfg_data_i;
        brp_pkg::CFG_JOY_LAST:    cfg_q.joy_last    <= cfg_data_i;
        brp_pkg::CFG_JOY2_FIRST:  cfg_q.joy2_first  <= cfg_data_i;
        brp_pkg::CFG_JOY2_LAST:   cfg_q.joy2_last   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o     = res_valid_q;
  assign bind_valid_o    = res_q.bind_valid;
  assign button_o        = res_q.button;
  assign analog_o        = res_q.analog;
  assign key_total_o     = res_q.key_total;
  assign has_name_o      = res_q.has_name;
  assign name_offset_o   = res_q.name_offset;
  assign keys_o          = res_q.keys;
  assign last_o          = res_q.last;
  assign uses_joystick_o = res_q.uses_joystick;

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bind_valid_o |-> last_o)
    else $error("end marker without last");

  a_joy_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !uses_joystick_o)
    else $error("joystick flag on a non-final beat");

  a_binding_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bind_valid_o |-> (button_o < brp_pkg::WheelId)
      && (key_total_o != '0) && (key_total_o <= 4'd8))
    else $error("kept binding with bad button or key count");

  a_key_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_KEYS |-> key_index_q < cur_key_total_q)
    else $error("key index ran past the record");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("byte taken while a result waits");

endmodule

`default_nettype wire

### src/brp_key_class.sv
// Classifies one key code against the configured playable and joystick ranges.
`default_nettype none

module brp_key_class (
  input  logic [brp_pkg::ByteW-1:0] key_i,
  input  brp_pkg::cfg_t             cfg_i,
  output brp_pkg::key_class_t       class_o
);

  logic in_keyb, in_mouse, in_joy, in_joy2;

  assign in_keyb  = (key_i > cfg_i.key_floor) && (key_i < cfg_i.key_ceiling);
  assign in_mouse = (key_i >= cfg_i.mouse_first) && (key_i <= cfg_i.mouse_last);
  assign in_joy   = (key_i >= cfg_i.joy_first) && (key_i <= cfg_i.joy_last);
  assign in_joy2  = (key_i >= cfg_i.joy2_first) && (key_i <= cfg_i.joy2_last);

  assign class_o.playable = in_keyb || in_mouse || in_joy || in_joy2;
  // Detection spans both joysticks, gaps included.
  assign class_o.joystick = (key_i >= cfg_i.joy_first) && (key_i <= cfg_i.joy2_last);

endmodule

`default_nettype wire
